// ===== rtl/rotq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rotq_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  // position counters, count registers, store address
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W   = $clog2(MAX_COLS + 1);
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int PIX_W    = 8;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // write pixel_in, advance load position
    logic fetch;  // read store, advance read position
    logic early;  // fetch before the frame is complete
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_full;
  } status_t;

  function automatic logic [RCNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [RCNT_W-1:0] r;
    if (v == '0) begin
      r = RCNT_W'(1);
    end else if (int'(v) > MAX_ROWS) begin
      r = RCNT_W'(MAX_ROWS);
    end else begin
      r = RCNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CCNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [CCNT_W-1:0] r;
    if (v == '0) begin
      r = CCNT_W'(1);
    end else if (int'(v) > MAX_COLS) begin
      r = CCNT_W'(MAX_COLS);
    end else begin
      r = CCNT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rotq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rotq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           mode,
  input  wire rotq_pkg::status_t status,
  output rotq_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                strobe
);
  import rotq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    strobe     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            // every fetch beats out one result, strobed in ST_RESULT
            cmd.fetch  = status.frame_full;
            cmd.early  = !status.frame_full;
            state_next = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        busy       = 1'b1;
        strobe     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_fetch_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_FETCH) |=> strobe)
    else $error("fetch without result");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_LOAD) |=> !strobe)
    else $error("result after load");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result repeated");

endmodule

`default_nettype wire

// ===== rtl/rotq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rotq_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rotq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rotq_pkg::CFG_W-1:0]      cfg_data,
  input  wire rotq_pkg::cmd_t                  cmd,
  input  wire logic [rotq_pkg::PIX_W-1:0]      pixel_in,
  output rotq_pkg::status_t                    status,
  output logic [rotq_pkg::PIX_W-1:0]           pixel_out,
  output logic                                 last_of_frame,
  output logic                                 not_ready
);
  import rotq_pkg::*;

  logic [RCNT_W-1:0] rows;
  logic [CCNT_W-1:0] cols;
  logic [ROW_W-1:0]  load_row;
  logic [COL_W-1:0]  load_col;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;
  logic              frame_full;
  logic              last_q;
  logic              nr_q;

  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rd_data;

  logic              load_row_end;
  logic              load_col_end;
  logic              read_col_end;
  logic              read_row_end;
  logic [ROW_W-1:0]  src_row;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              new_frame;

  assign load_row_end = (RCNT_W'(load_row) + RCNT_W'(1)) >= rows;
  assign load_col_end = (CCNT_W'(load_col) + CCNT_W'(1)) >= cols;
  assign read_col_end = (CCNT_W'(read_col) + CCNT_W'(1)) >= cols;
  assign read_row_end = (RCNT_W'(read_row) + RCNT_W'(1)) >= rows;
  assign new_frame    = (load_row == '0) && (load_col == '0);

  // source rows walk bottom to top
  assign src_row = ROW_W'(rows - RCNT_W'(1) - RCNT_W'(read_row));
  assign waddr   = ADDR_W'(load_row) + ADDR_W'(load_col) * ADDR_W'(MAX_ROWS);
  assign raddr   = ADDR_W'(src_row) + ADDR_W'(read_col) * ADDR_W'(MAX_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows       <= RCNT_W'(MAX_ROWS);
      cols       <= CCNT_W'(MAX_COLS);
      load_row   <= '0;
      load_col   <= '0;
      read_row   <= '0;
      read_col   <= '0;
      frame_full <= 1'b0;
      last_q     <= 1'b0;
      nr_q       <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT)) begin
        if (cfg_index == REG_ROW_COUNT) begin
          rows <= clamp_rows(cfg_data);
        end else begin
          cols <= clamp_cols(cfg_data);
        end
        load_row   <= '0;
        load_col   <= '0;
        read_row   <= '0;
        read_col   <= '0;
        frame_full <= 1'b0;
      end else if (cmd.load) begin
        if (new_frame) begin
          read_row   <= '0;
          read_col   <= '0;
          frame_full <= 1'b0;
        end
        if (load_row_end) begin
          load_row <= '0;
          if (load_col_end) begin
            load_col   <= '0;
            frame_full <= 1'b1;
          end else begin
            load_col <= load_col + COL_W'(1);
          end
        end else begin
          load_row <= load_row + ROW_W'(1);
        end
      end else if (cmd.fetch) begin
        nr_q   <= 1'b0;
        last_q <= read_col_end && read_row_end;
        if (read_col_end) begin
          read_col <= '0;
          if (read_row_end) begin
            read_row <= '0;
          end else begin
            read_row <= read_row + ROW_W'(1);
          end
        end else begin
          read_col <= read_col + COL_W'(1);
        end
      end else if (cmd.early) begin
        nr_q   <= 1'b1;
        last_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[waddr] <= pixel_in;
    end
    if (cmd.fetch) begin
      rd_data <= mem[raddr];
    end
  end

  assign status.frame_full = frame_full;
  assign pixel_out         = nr_q ? '0 : rd_data;
  assign last_of_frame     = last_q;
  assign not_ready         = nr_q;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(nr_q && last_q))
    else $error("not_ready together with last_of_frame");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.fetch, cmd.early}))
    else $error("conflicting datapath commands");

  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    (RCNT_W'(read_row) < rows) && (CCNT_W'(read_col) < cols))
    else $error("read position outside the frame");

endmodule

`default_nettype wire

// ===== rtl/image_rotate_quarter_turn_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Quarter-turn (90 degrees clockwise) rotator for a byte image of up to
// 64 x 64 pixels. Set row_count / col_count (0 acts as 1, above 64 acts as 64)
// while idle; a write to either count restarts the frame. Pulse start with mode = 0 to load
// the next source pixel (column-major, row index fastest) and mode = 1 to
// fetch the next rotated pixel. On a load busy stays low and no result beat
// follows. On a fetch the store is read in the accepting cycle, and the
// result beat appears on the next cycle for exactly one cycle with
// result_strobe high, while busy is high. The receiver cannot stall,
// so the beat must be captured when strobed. A fetch before the frame is
// complete returns not_ready with pixel_out zero. last_of_frame marks the
// final pixel; fetching on returns the same frame again. The frame store has
// no reset and needs no clearing pass; only written pixels are ever read.

module image_rotate_quarter_turn_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [rotq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rotq_pkg::CFG_W-1:0]      cfg_data,
  // command
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            mode,
  input  wire logic [rotq_pkg::PIX_W-1:0]      pixel_in,
  // result beat
  output logic                                 result_strobe,
  output logic [rotq_pkg::PIX_W-1:0]           pixel_out,
  output logic                                 last_of_frame,
  output logic                                 not_ready
);
  import rotq_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: decodes accepted commands, times the result beat
  rotq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (result_strobe)
  );

  // counters, frame store and result registers
  rotq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .pixel_in      (pixel_in),
    .status        (status),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame),
    .not_ready     (not_ready)
  );

endmodule

`default_nettype wire

// ===== dv/rotq_frame_checker.sv =====
`timescale 1ns / 1ps

// Watches the config port, the command beats and the result beats of the
// quarter-turn rotator, predicts every fetch and compares it field by field.
module rotq_frame_checker
  import rotq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 mode,
  input  logic [PIX_W-1:0]     pixel_in,
  input  logic                 result_strobe,
  input  logic [PIX_W-1:0]     pixel_out,
  input  logic                 last_of_frame,
  input  logic                 not_ready,
  output int                   fail_count,
  output int                   outstanding
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             early;
  } rot_beat_t;

  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  int               ld_row;
  int               ld_col;
  int               rd_row;
  int               rd_col;
  bit               have_frame;
  rot_beat_t        pending_pixels [$];
  int               err_count = 0;

  assign fail_count = err_count;

  // out-of-range counts: zero acts as one, above the max acts as the max
  function automatic int span(input logic [CFG_W-1:0] raw, input int limit);
    if (raw == '0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic void restart_frame();
    ld_row     = 0;
    ld_col     = 0;
    rd_row     = 0;
    rd_col     = 0;
    have_frame = 1'b0;
  endfunction

  // source pixels arrive column-major, row index fastest
  function automatic void store_pixel(input logic [PIX_W-1:0] pix);
    if (ld_row == 0 && ld_col == 0) begin
      have_frame = 1'b0;
      rd_row     = 0;
      rd_col     = 0;
    end
    frame_mem[ld_row + MAX_ROWS * ld_col] = pix;
    ld_row++;
    if (ld_row >= span(rows_reg, MAX_ROWS)) begin
      ld_row = 0;
      ld_col++;
      if (ld_col >= span(cols_reg, MAX_COLS)) begin
        ld_col     = 0;
        have_frame = 1'b1;
      end
    end
  endfunction

  // rotated order: source rows last to first, each row left to right
  function automatic rot_beat_t next_rotated_pixel();
    rot_beat_t b;
    int        rows;
    int        cols;
    b    = '0;
    rows = span(rows_reg, MAX_ROWS);
    cols = span(cols_reg, MAX_COLS);
    if (!have_frame) begin
      b.early = 1'b1;
      return b;
    end
    b.pixel = frame_mem[(rows - 1 - rd_row) + MAX_ROWS * rd_col];
    rd_col++;
    if (rd_col >= cols) begin
      rd_col = 0;
      rd_row++;
      if (rd_row >= rows) begin
        rd_row = 0;
        b.last = 1'b1;
      end
    end
    return b;
  endfunction

  always @(posedge clk) begin : watch
    rot_beat_t want;
    if (rst) begin
      rows_reg = CFG_W'(MAX_ROWS);
      cols_reg = CFG_W'(MAX_COLS);
      restart_frame();
      pending_pixels.delete();
    end else begin
      if (result_strobe) begin
        if (pending_pixels.size() == 0) begin
          $error("result beat with no fetch outstanding: pixel_out %0d", pixel_out);
          err_count++;
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, pixel_out);
            err_count++;
          end
          if (last_of_frame !== want.last) begin
            $error("last_of_frame: expected %0d, got %0d", want.last, last_of_frame);
            err_count++;
          end
          if (not_ready !== want.early) begin
            $error("not_ready: expected %0d, got %0d", want.early, not_ready);
            err_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_ROW_COUNT) begin
          rows_reg = cfg_data;
          restart_frame();
        end else if (cfg_index == REG_COL_COUNT) begin
          cols_reg = cfg_data;
          restart_frame();
        end
      end
      if (start && !busy) begin
        if (mode == MODE_LOAD) begin
          store_pixel(pixel_in);
        end else begin
          pending_pixels.push_back(next_rotated_pixel());
        end
      end
    end
    outstanding <= pending_pixels.size();
  end

endmodule

// ===== dv/image_rotate_quarter_turn_core_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the quarter-turn rotator. All prediction and
// comparison lives in rotq_frame_checker, which sits beside the block and
// only watches its ports.
module image_rotate_quarter_turn_core_tb;
  import rotq_pkg::*;

  // the two indexes the block does not decode; writes there must not restart
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int ITEM_TARGET  = 900;
  // a load never strobes, so a last load may still be in flight when the
  // checker has nothing outstanding
  localparam int DRAIN_CYCLES = 4;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 start     = 1'b0;
  logic                 busy;
  logic                 mode      = MODE_LOAD;
  logic [PIX_W-1:0]     pixel_in  = '0;
  logic                 result_strobe;
  logic [PIX_W-1:0]     pixel_out;
  logic                 last_of_frame;
  logic                 not_ready;

  int fail_count;
  int outstanding;
  int items_sent = 0;
  bit no_gaps    = 1'b0;  // burst phases: start held high back to back
  int frame_rows = MAX_ROWS;
  int frame_cols = MAX_COLS;

  image_rotate_quarter_turn_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .pixel_in      (pixel_in),
    .result_strobe (result_strobe),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame),
    .not_ready     (not_ready)
  );

  rotq_frame_checker rotation_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .pixel_in      (pixel_in),
    .result_strobe (result_strobe),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame),
    .not_ready     (not_ready),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: stops a run that hangs and reports it as failed
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // One command beat. The idle gap is drawn per beat; with no gap, start
  // simply stays high and only the payload changes. Returns on the edge
  // that accepts the beat (start high, busy low).
  task automatic issue(input logic m, input logic [PIX_W-1:0] p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    mode     <= m;
    pixel_in <= p;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Drop start, wait for every fetch beat to come back, then let any
  // trailing load finish before the config port is touched.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // the trailing low cycle keeps back-to-back writes to one drive per edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // program both counts in random order and note the effective frame shape
  task automatic shape_frame(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_ROW_COUNT, r);
      write_reg(REG_COL_COUNT, c);
    end else begin
      write_reg(REG_COL_COUNT, c);
      write_reg(REG_ROW_COUNT, r);
    end
    frame_rows = (r == '0) ? 1 : ((int'(r) > MAX_ROWS) ? MAX_ROWS : int'(r));
    frame_cols = (c == '0) ? 1 : ((int'(c) > MAX_COLS) ? MAX_COLS : int'(c));
  endtask

  // edge values of a count register: zero, one, the max, above the max
  function automatic logic [CFG_W-1:0] extreme_count(input int limit);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(limit);
      3:       return '1;
      default: return CFG_W'($urandom_range(limit + 1, 126));
    endcase
  endfunction

  initial begin : stimulus
    int pick;
    int area;
    int frames;
    int kind;
    int loads;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // fetch straight out of reset: frame not loaded yet
    issue(MODE_FETCH, 8'hA5);

    // row count zero acts as one: a 1x1 frame, fetched twice to see the wrap
    settle();
    shape_frame(CFG_W'(0), CFG_W'(1));
    issue(MODE_LOAD, 8'hFF);
    issue(MODE_FETCH, 8'h00);
    issue(MODE_FETCH, 8'h00);
    // a load at the first position starts a new frame
    issue(MODE_LOAD, 8'h00);
    issue(MODE_FETCH, 8'hFF);

    // 3 rows x 2 cols, with a fetch while the frame is half loaded
    settle();
    shape_frame(CFG_W'(3), CFG_W'(2));
    issue(MODE_LOAD, 8'h00);
    issue(MODE_LOAD, 8'hFF);
    issue(MODE_LOAD, 8'h5A);
    issue(MODE_FETCH, 8'h00);
    issue(MODE_LOAD, 8'hA5);
    issue(MODE_LOAD, 8'h0F);
    issue(MODE_LOAD, 8'hF0);
    repeat (2) issue(MODE_FETCH, PIX_W'($urandom_range(0, 255)));
    // undecoded index: read position must carry on, then wrap
    settle();
    write_reg(REG_SPARE_A, '1);
    repeat (5) issue(MODE_FETCH, PIX_W'($urandom_range(0, 255)));
    // rewriting a count with its current value still restarts the frame
    settle();
    write_reg(REG_COL_COUNT, CFG_W'(2));
    issue(MODE_FETCH, 8'hFF);

    // --- random phases ---
    while (items_sent < ITEM_TARGET) begin
      settle();
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        shape_frame(extreme_count(MAX_ROWS), CFG_W'($urandom_range(0, 4)));
      end else if (pick == 1) begin
        shape_frame(CFG_W'($urandom_range(0, 4)), extreme_count(MAX_COLS));
      end else begin
        shape_frame(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_W'($urandom_range(0, 127)));
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      area    = frame_rows * frame_cols;
      frames  = (area > 64) ? 1 : $urandom_range(1, 3);

      repeat (frames) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          // noise: loads and fetches in any order
          repeat ($urandom_range(1, 16)) begin
            issue(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)));
          end
        end else begin
          // a full frame, or a short one that leaves the next frame offset
          loads = (kind == 1) ? $urandom_range(1, area) : area;
          for (int i = 0; i < loads; i++) begin
            if ($urandom_range(0, 15) == 0) begin
              issue(MODE_FETCH, PIX_W'($urandom_range(0, 255)));
            end
            issue(MODE_LOAD, PIX_W'($urandom_range(0, 255)));
          end
          // read back, often past the last pixel to exercise the wrap
          repeat ($urandom_range(1, 2 * area + 1)) begin
            issue(MODE_FETCH, PIX_W'($urandom_range(0, 255)));
          end
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
